FILE: rtl/tgf_pkg.sv
`default_nettype none

package tgf_pkg;

   localparam int NUM_TEAMS_DEF  = 12;
   localparam int TEAM_DEPTH_DEF = 256;

   localparam int KIND_W   = 1;
   localparam int TEAM_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_ENQ = 1'b0;
   localparam logic [KIND_W-1:0] KIND_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic push;
      logic pop;
      logic rd_en;
   } order_ctrl_type;

   typedef struct packed {
      logic empty;
   } order_stat_type;

endpackage

`default_nettype wire

FILE: rtl/tgf_ifs.sv
`default_nettype none

interface tgf_req_if
   import tgf_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic        [KIND_W-1:0]   kind;
   logic        [TEAM_W-1:0]   team;
   logic signed [VALUE_W-1:0]  member_value;

   modport source (output valid, kind, team, member_value, input ready);
   modport sink   (input valid, kind, team, member_value, output ready);
endinterface

interface tgf_rsp_if
   import tgf_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  out_value;
   logic        [TEAM_W-1:0]   out_team;
   logic        [STATUS_W-1:0] status;

   modport source (output valid, out_value, out_team, status, input ready);
   modport sink   (input valid, out_value, out_team, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/tgf_store.sv
`default_nettype none

module tgf_store
   import tgf_pkg::*;
#(
   parameter int NUM_TEAMS  = NUM_TEAMS_DEF,
   parameter int TEAM_DEPTH = TEAM_DEPTH_DEF,
   localparam int ADDR_W    = $clog2(NUM_TEAMS * TEAM_DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [VALUE_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output      logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [NUM_TEAMS * TEAM_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/tgf_order.sv
`default_nettype none

module tgf_order
   import tgf_pkg::*;
#(
   parameter int NUM_TEAMS = NUM_TEAMS_DEF,
   localparam int IDX_W    = $clog2(NUM_TEAMS),
   localparam int CNT_W    = $clog2(NUM_TEAMS + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire order_ctrl_type   ctrl,
   input  wire logic [IDX_W-1:0] push_team,
   output      logic [IDX_W-1:0] front_team,
   output      order_stat_type   stat
);

   logic [IDX_W-1:0] ring [NUM_TEAMS];
   logic [IDX_W-1:0] front_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctrl.push) begin
         tail_in = (tail_ff == IDX_W'(NUM_TEAMS - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (ctrl.pop) begin
         head_in = (head_ff == IDX_W'(NUM_TEAMS - 1)) ? '0 : head_ff + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         ring[tail_ff] <= push_team;
      end
      if (ctrl.rd_en) begin
         front_ff <= ring[head_ff];
      end
   end

   assign front_team = front_ff;
   assign stat.empty = (fill_ff == '0);

endmodule

`default_nettype wire

FILE: rtl/team_grouped_fifo_core.sv
// Team queue. Items arrive on req_bus, one beat per operation: kind selects
// enqueue or dequeue, team and member_value matter for enqueue only. Every
// request beat yields exactly one response beat on rsp_bus carrying the
// dequeued value and its team, both zero for any other response, and a status
// code (ok, team full, queue empty, team out of range).
// The block handles one operation at a time. An enqueue with its team out of
// range or a dequeue from an empty queue goes straight to its response, any
// other enqueue first reads the team table, and a dequeue reads the order
// ring, then the team table, then the member store. Each of these memory
// reads is registered.
// The response is held in an output register. While the receiver stalls,
// the beat stays on rsp_bus and no new request is accepted.
// Reset is synchronous. It empties every team through the per-team listed
// flags and the order ring by its pointer reset; no clearing pass over the
// memories is needed, and requests are accepted in the first cycle after reset.
`default_nettype none

module team_grouped_fifo_core
   import tgf_pkg::*;
#(
   parameter int NUM_TEAMS  = NUM_TEAMS_DEF,
   parameter int TEAM_DEPTH = TEAM_DEPTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   tgf_req_if.sink   req_bus,
   tgf_rsp_if.source rsp_bus
);

   localparam int IDX_W  = $clog2(NUM_TEAMS);
   localparam int PTR_W  = $clog2(TEAM_DEPTH);
   localparam int FILL_W = $clog2(TEAM_DEPTH + 1);
   localparam int ENT_W  = 2 * PTR_W + FILL_W;
   localparam int ADDR_W = $clog2(NUM_TEAMS * TEAM_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RING  = 3'd1;
   localparam logic [2:0] S_TEAM  = 3'd2;
   localparam logic [2:0] S_STORE = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [TEAM_W-1:0]   rsp_team_ff, rsp_team_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [NUM_TEAMS-1:0] listed_ff, listed_in;

   logic [ENT_W-1:0] team_mem [NUM_TEAMS];
   logic [ENT_W-1:0] team_rd_ff;
   logic             team_re, team_we;
   logic [IDX_W-1:0] team_raddr;
   logic [ENT_W-1:0] team_wdata;

   logic [PTR_W-1:0]  ent_head, ent_tail, head_nxt, tail_nxt;
   logic [FILL_W-1:0] ent_fill;
   logic [ADDR_W-1:0] team_base;

   logic               accept;
   logic               out_of_range;
   logic [IDX_W-1:0]   req_idx;
   order_ctrl_type     order_ctrl;
   order_stat_type     order_stat;
   logic [IDX_W-1:0]   front_idx;

   logic               st_we, st_re;
   logic [ADDR_W-1:0]  st_waddr, st_raddr;
   logic [VALUE_W-1:0] st_rdata;

   tgf_order #(
      .NUM_TEAMS (NUM_TEAMS)
   ) u_order (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (order_ctrl),
      .push_team  (idx_ff),
      .front_team (front_idx),
      .stat       (order_stat)
   );

   tgf_store #(
      .NUM_TEAMS  (NUM_TEAMS),
      .TEAM_DEPTH (TEAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (value_ff),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_of_range  = (req_bus.team == '0) || (32'(req_bus.team) > NUM_TEAMS);
   assign req_idx       = IDX_W'(32'(req_bus.team) - 32'd1);

   assign {ent_head, ent_tail, ent_fill} = listed_ff[idx_ff] ? team_rd_ff : '0;
   assign head_nxt  = (ent_head == PTR_W'(TEAM_DEPTH - 1)) ? '0 : ent_head + 1'b1;
   assign tail_nxt  = (ent_tail == PTR_W'(TEAM_DEPTH - 1)) ? '0 : ent_tail + 1'b1;
   assign team_base = ADDR_W'(idx_ff) * ADDR_W'(TEAM_DEPTH);
   assign st_waddr  = team_base + ADDR_W'(ent_tail);
   assign st_raddr  = team_base + ADDR_W'(ent_head);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_team_in   = rsp_team_ff;
      rsp_status_in = rsp_status_ff;
      listed_in     = listed_ff;
      team_re       = 1'b0;
      team_raddr    = req_idx;
      team_we       = 1'b0;
      team_wdata    = {ent_head, ent_tail, ent_fill};
      order_ctrl    = '0;
      st_we         = 1'b0;
      st_re         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in      = req_bus.kind;
               idx_in       = req_idx;
               value_in     = req_bus.member_value;
               rsp_value_in = '0;
               rsp_team_in  = '0;
               if (req_bus.kind == KIND_ENQ) begin
                  if (out_of_range) begin
                     rsp_status_in = ST_RANGE;
                     state_in      = S_RESP;
                  end else begin
                     team_re  = 1'b1;
                     state_in = S_TEAM;
                  end
               end else if (order_stat.empty) begin
                  rsp_status_in = ST_EMPTY;
                  state_in      = S_RESP;
               end else begin
                  order_ctrl.rd_en = 1'b1;
                  state_in         = S_RING;
               end
            end
         end
         S_RING: begin
            idx_in     = front_idx;
            team_re    = 1'b1;
            team_raddr = front_idx;
            state_in   = S_TEAM;
         end
         S_TEAM: begin
            if (kind_ff == KIND_ENQ) begin
               state_in = S_RESP;
               if (ent_fill == FILL_W'(TEAM_DEPTH)) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_OK;
                  st_we         = 1'b1;
                  team_we       = 1'b1;
                  team_wdata    = {ent_head, tail_nxt, ent_fill + 1'b1};
                  if (!listed_ff[idx_ff]) begin
                     listed_in[idx_ff] = 1'b1;
                     order_ctrl.push   = 1'b1;
                  end
               end
            end else begin
               st_re      = 1'b1;
               team_we    = 1'b1;
               team_wdata = {head_nxt, ent_tail, ent_fill - 1'b1};
               if (ent_fill == FILL_W'(1)) begin
                  listed_in[idx_ff] = 1'b0;
                  order_ctrl.pop    = 1'b1;
               end
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            rsp_value_in  = st_rdata;
            rsp_team_in   = TEAM_W'(32'(idx_ff) + 32'd1);
            rsp_status_in = ST_OK;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         listed_ff <= '0;
      end else begin
         state_ff  <= state_in;
         listed_ff <= listed_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      value_ff      <= value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_team_ff   <= rsp_team_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (team_we) begin
         team_mem[idx_ff] <= team_wdata;
      end
      if (team_re) begin
         team_rd_ff <= team_mem[team_raddr];
      end
   end

   assign rsp_bus.valid     = (state_ff == S_RESP);
   assign rsp_bus.out_value = rsp_value_ff;
   assign rsp_bus.out_team  = rsp_team_ff;
   assign rsp_bus.status    = rsp_status_ff;

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !rsp_bus.valid)
      else $error("request ready while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("second request accepted while busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != ST_OK) |->
         (rsp_bus.out_value == '0 && rsp_bus.out_team == '0))
      else $error("error response carries data");

   a_ring_matches_listed: assert property (@(posedge clock) disable iff (reset)
      order_stat.empty == (listed_ff == '0))
      else $error("order ring occupancy disagrees with listed flags");

   a_ok_deq_has_team: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE) |=> (rsp_bus.valid && rsp_bus.out_team != '0))
      else $error("dequeue response without a team");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
   import tgf_pkg::*;

   typedef struct {
      logic signed [VALUE_W-1:0]  out_value;
      logic        [TEAM_W-1:0]   out_team;
      logic        [STATUS_W-1:0] status;
   } rsp_beat_type;

   class team_queue_model;
      logic signed [VALUE_W-1:0] members [NUM_TEAMS_DEF][$];
      logic [TEAM_W-1:0]         team_order[$];
      rsp_beat_type              pending_beats[$];
      int                        errors;

      function new();
         errors = 0;
      endfunction

      function int held_count();
         int sum;
         sum = 0;
         for (int t = 0; t < NUM_TEAMS_DEF; t++) sum += members[t].size();
         return sum;
      endfunction

      function void note_request(input logic [KIND_W-1:0] kind, input logic [TEAM_W-1:0] team,
                                 input logic signed [VALUE_W-1:0] value);
         rsp_beat_type beat;
         logic [TEAM_W-1:0] front;
         beat.out_value = '0;
         beat.out_team  = '0;
         beat.status    = ST_OK;
         if (kind == KIND_ENQ) begin
            if (team == 0 || team > NUM_TEAMS_DEF) begin
               beat.status = ST_RANGE;
            end else if (members[team-1].size() >= TEAM_DEPTH_DEF) begin
               beat.status = ST_FULL;
            end else begin
               // A team is listed in the order exactly while its queue holds values.
               if (members[team-1].size() == 0) team_order.push_back(team);
               members[team-1].push_back(value);
            end
         end else begin
            if (team_order.size() == 0) begin
               beat.status = ST_EMPTY;
            end else begin
               front = team_order[0];
               beat.out_value = members[front-1].pop_front();
               beat.out_team  = front;
               if (members[front-1].size() == 0) void'(team_order.pop_front());
            end
         end
         pending_beats.push_back(beat);
      endfunction

      function void check_response(input logic signed [VALUE_W-1:0] value,
                                   input logic [TEAM_W-1:0] team,
                                   input logic [STATUS_W-1:0] status);
         rsp_beat_type want;
         if (pending_beats.size() == 0) begin
            $display("%0t: response beat with none expected: value %0d team %0d status %0d",
                     $time, value, team, status);
            errors++;
         end else begin
            want = pending_beats.pop_front();
            if (value !== want.out_value) begin
               $display("%0t: out_value mismatch: expected %0d, actual %0d",
                        $time, want.out_value, value);
               errors++;
            end
            if (team !== want.out_team) begin
               $display("%0t: out_team mismatch: expected %0d, actual %0d",
                        $time, want.out_team, team);
               errors++;
            end
            if (status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, status);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle;
   int   recv_idle;

   team_queue_model tq;

   tgf_req_if req_bus ();
   tgf_rsp_if rsp_bus ();

   team_grouped_fifo_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [TEAM_W-1:0] team,
                          input logic signed [VALUE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.kind         = kind;
      req_bus.team         = team;
      req_bus.member_value = value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tq.note_request(kind, team, value);
   endtask

   task automatic run_mixed(input int count);
      int r;
      int hi;
      logic signed [VALUE_W-1:0] v;
      hi = NUM_TEAMS_DEF;
      for (int i = 0; i < count; i++) begin
         // Every 40 operations, pick at random between three busy teams and the full team range.
         if (i % 40 == 0) hi = ($urandom_range(1) == 0) ? 3 : NUM_TEAMS_DEF;
         r = $urandom_range(99);
         case ($urandom_range(7))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            default: v = $urandom;
         endcase
         if (r < 3) begin
            send_op(KIND_ENQ, ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15, 13)), v);
         end else if (r < 55) begin
            send_op(KIND_ENQ, 4'($urandom_range(hi, 1)), v);
         end else begin
            send_op(KIND_DEQ, 4'($urandom_range(15)), v);
         end
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(99) >= recv_idle);
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            tq.check_response(rsp_bus.out_value, rsp_bus.out_team, rsp_bus.status);
         end
      end
   end

   initial begin
      int burst_team;
      tq = new();
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_ENQ;
      req_bus.team         = '0;
      req_bus.member_value = '0;
      send_idle            = 20;
      recv_idle            = 75;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_op(KIND_DEQ, 4'd0, 32'sd0);
      send_op(KIND_ENQ, 4'd0, 32'sh7fff_ffff);
      send_op(KIND_ENQ, 4'd13, 32'sd1);
      send_op(KIND_ENQ, 4'd15, 32'sh8000_0000);
      send_op(KIND_ENQ, 4'd1, 32'sh8000_0000);
      send_op(KIND_ENQ, 4'd2, 32'sh7fff_ffff);
      send_op(KIND_ENQ, 4'd3, 32'sd0);
      send_op(KIND_ENQ, 4'd4, -32'sd1);
      for (int t = 5; t <= NUM_TEAMS_DEF; t++) send_op(KIND_ENQ, 4'(t), $urandom);
      send_op(KIND_ENQ, 4'd1, 32'sd7);
      send_op(KIND_ENQ, 4'd12, 32'sd12);
      send_op(KIND_DEQ, 4'd15, 32'sh7fff_ffff);
      send_op(KIND_DEQ, 4'd1, 32'sh8000_0000);
      send_op(KIND_DEQ, 4'd0, 32'sd0);
      send_op(KIND_DEQ, 4'd12, -32'sd1);

      run_mixed(130);

      send_idle = 75;
      recv_idle = 20;
      run_mixed(130);

      send_idle = 0;
      recv_idle = 0;
      run_mixed(130);

      // Fill one team past its depth, then drain everything.
      burst_team = $urandom_range(NUM_TEAMS_DEF, 1);
      for (int i = 0; i < TEAM_DEPTH_DEF + 2; i++) send_op(KIND_ENQ, 4'(burst_team), $urandom);
      while (tq.held_count() > 0) send_op(KIND_DEQ, 4'($urandom_range(15)), $urandom);
      send_op(KIND_DEQ, 4'($urandom_range(15)), $urandom);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tq.pending_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tq.errors == 0) begin
         $display("team_grouped_fifo_core regression: pass");
      end else begin
         $display("team_grouped_fifo_core regression: fail");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("team_grouped_fifo_core regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
